// ----- hw/rtl/whrol_pkg.sv -----
// Package for the write history ring with offset lookup.
// Holds the operation codes, the fixed port field widths and the entry and query types.
// No dependencies.
package whrol_pkg;

    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFSET_W = 20;
    localparam int SLOT_W   = 4;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_FIND = 1'b1;

    typedef struct packed {
        logic                occ;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } whrol_ent_t;

    typedef struct packed {
        logic                vld;
        logic                hit;
        logic [OFFSET_W-1:0] rem;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
    } whrol_qry_t;

endpackage

// ----- hw/rtl/write_history_ring_with_offset_lookup_core.sv -----
// A ring of the most recent DEPTH writes, each a buffer handle and a byte size. An add
// transaction stores an entry and returns its result in the cycle after acceptance; when the ring
// is full the oldest entry is overwritten and reported as evicted. A find transaction treats
// the held entries, oldest first, as one byte stream, skipping entries with a zero handle or
// size, and returns the slot, handle and in-entry offset of the byte asked for. Entries sit in
// a chain of cells ordered by age; a find query moves one cell per cycle, and its result is
// registered after the last cell. One transaction is processed at a time, and a new one is
// accepted in the cycle the previous result is taken. Reset empties the ring at once.
// Depends on whrol_pkg and whrol_cell.
module write_history_ring_with_offset_lookup_core
    import whrol_pkg::*;
#(
    parameter int DEPTH       = 10,
    parameter int SIZE_BITS   = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [HANDLE_W-1:0] s_entry_handle,
    input  logic [SIZE_W-1:0]   s_entry_size,
    input  logic [OFFSET_W-1:0] s_stream_offset,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [SLOT_W-1:0]   m_found_slot,
    output logic [HANDLE_W-1:0] m_found_handle,
    output logic [SIZE_W-1:0]   m_offset_in_entry,
    output logic                m_evicted,
    output logic [HANDLE_W-1:0] m_evicted_handle,
    output logic [SIZE_W-1:0]   m_evicted_size
);

    localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int SW = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0] count_reg;
    logic [IW-1:0] ins_reg;
    logic          busy_reg;
    logic          m_valid_reg;

    logic                found_reg;
    logic [SLOT_W-1:0]   found_slot_reg;
    logic [HANDLE_W-1:0] found_handle_reg;
    logic [SIZE_W-1:0]   offset_reg;
    logic                evicted_reg;
    logic [HANDLE_W-1:0] ev_handle_reg;
    logic [SIZE_W-1:0]   ev_size_reg;

    logic       acc;
    logic       add_acc;
    logic       find_acc;
    logic       full;
    whrol_ent_t new_ent;
    whrol_ent_t ent_out [DEPTH];
    whrol_ent_t ent_in  [DEPTH];
    logic       ent_we  [DEPTH];
    whrol_qry_t q_chain [DEPTH+1];
    whrol_qry_t q_last;

    assign s_ready  = !busy_reg && (!m_valid_reg || m_ready);
    assign acc      = s_valid && s_ready;
    assign add_acc  = acc && (s_func == FUNC_ADD);
    assign find_acc = acc && (s_func == FUNC_FIND);
    assign full     = (count_reg == CW'(DEPTH));

    always_comb begin
        new_ent.occ    = 1'b1;
        new_ent.slot   = SLOT_W'(ins_reg);
        new_ent.handle = HANDLE_W'(s_entry_handle[HW-1:0]);
        new_ent.size   = SIZE_W'(s_entry_size[SW-1:0]);
    end

    always_comb begin
        q_chain[0].vld    = find_acc;
        q_chain[0].hit    = 1'b0;
        q_chain[0].rem    = s_stream_offset;
        q_chain[0].slot   = '0;
        q_chain[0].handle = '0;
    end

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        if (j < DEPTH - 1) begin : g_mid
            assign ent_in[j] = full ? ent_out[j+1] : new_ent;
        end else begin : g_end
            assign ent_in[j] = new_ent;
        end
        assign ent_we[j] = add_acc && (full || (count_reg == CW'(j)));

        whrol_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ent_we  (ent_we[j]),
            .ent_in  (ent_in[j]),
            .ent_out (ent_out[j]),
            .q_in    (q_chain[j]),
            .q_out   (q_chain[j+1])
        );
    end

    assign q_last = q_chain[DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ins_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (add_acc) begin
                m_valid_reg <= 1'b1;
                ins_reg     <= (ins_reg == IW'(DEPTH - 1)) ? '0 : ins_reg + IW'(1);
                if (!full) begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (find_acc) begin
                busy_reg <= 1'b1;
            end
            if (q_last.vld) begin
                busy_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (add_acc) begin
            found_reg        <= 1'b0;
            found_slot_reg   <= '0;
            found_handle_reg <= '0;
            offset_reg       <= '0;
            evicted_reg      <= full;
            ev_handle_reg    <= full ? ent_out[0].handle : '0;
            ev_size_reg      <= full ? ent_out[0].size : '0;
        end else if (q_last.vld) begin
            found_reg        <= q_last.hit;
            found_slot_reg   <= q_last.hit ? q_last.slot : '0;
            found_handle_reg <= q_last.hit ? q_last.handle : '0;
            offset_reg       <= q_last.hit ? q_last.rem[SIZE_W-1:0] : '0;
            evicted_reg      <= 1'b0;
            ev_handle_reg    <= '0;
            ev_size_reg      <= '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = found_reg;
    assign m_found_slot      = found_slot_reg;
    assign m_found_handle    = found_handle_reg;
    assign m_offset_in_entry = offset_reg;
    assign m_evicted         = evicted_reg;
    assign m_evicted_handle  = ev_handle_reg;
    assign m_evicted_size    = ev_size_reg;

endmodule

// ----- hw/rtl/whrol_cell.sv -----
// One cell of the age-ordered entry chain: one stored entry and one stage of the find query.
// Depends on whrol_pkg.
module whrol_cell
    import whrol_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       ent_we,
    input  whrol_ent_t ent_in,
    output whrol_ent_t ent_out,
    input  whrol_qry_t q_in,
    output whrol_qry_t q_out
);

    whrol_ent_t ent_reg;
    whrol_qry_t q_reg;
    whrol_qry_t q_next;
    logic       live;

    assign live = ent_reg.occ && (ent_reg.handle != '0) && (ent_reg.size != '0);

    always_comb begin
        q_next = q_in;
        if (q_in.vld && !q_in.hit && live) begin
            if (q_in.rem < OFFSET_W'(ent_reg.size)) begin
                q_next.hit    = 1'b1;
                q_next.slot   = ent_reg.slot;
                q_next.handle = ent_reg.handle;
            end else begin
                q_next.rem = q_in.rem - OFFSET_W'(ent_reg.size);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
            q_reg   <= '0;
        end else begin
            if (ent_we) begin
                ent_reg <= ent_in;
            end
            q_reg <= q_next;
        end
    end

    assign ent_out = ent_reg;
    assign q_out   = q_reg;

endmodule

// ----- hw/rtl/whrol_checker.sv -----
// Port-level checker for the write history ring core, and the bind that attaches it.
// Depends on whrol_pkg and write_history_ring_with_offset_lookup_core.
module whrol_checker
    import whrol_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_func,
    input logic [HANDLE_W-1:0] s_entry_handle,
    input logic [SIZE_W-1:0]   s_entry_size,
    input logic [OFFSET_W-1:0] s_stream_offset,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_found,
    input logic [SLOT_W-1:0]   m_found_slot,
    input logic [HANDLE_W-1:0] m_found_handle,
    input logic [SIZE_W-1:0]   m_offset_in_entry,
    input logic                m_evicted,
    input logic [HANDLE_W-1:0] m_evicted_handle,
    input logic [SIZE_W-1:0]   m_evicted_size
);

    a_add_result_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FUNC_ADD)) |=> m_valid)
        else $error("An add transaction gave no result in the next cycle.");

    a_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted) |-> !m_found)
        else $error("A result reports both a found entry and an eviction.");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |->
        ((m_found_slot == '0) && (m_found_handle == '0) && (m_offset_in_entry == '0)))
        else $error("A result without a match carries nonzero find fields.");

    a_no_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |-> ((m_evicted_handle == '0) && (m_evicted_size == '0)))
        else $error("A result without an eviction carries nonzero eviction fields.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_found_handle)))
        else $error("A stalled result transaction changed or was dropped.");

endmodule

bind write_history_ring_with_offset_lookup_core whrol_checker u_whrol_checker (.*);

// ----- verif/tb_top.sv -----
// Testbench for write_history_ring_with_offset_lookup_core: directed and random add and find
// transactions under several idling phases, checked against an in-bench model of the ring.
// Depends on whrol_pkg and the RTL of the core.
`timescale 1ns / 100ps

module tb_top;
    import whrol_pkg::*;

    localparam int RING_DEPTH = 10;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   found_slot;
        logic [HANDLE_W-1:0] found_handle;
        logic [SIZE_W-1:0]   offset_in_entry;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
        logic [SIZE_W-1:0]   evicted_size;
    } ring_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_func = FUNC_ADD;
    logic [HANDLE_W-1:0] s_entry_handle = '0;
    logic [SIZE_W-1:0]   s_entry_size = '0;
    logic [OFFSET_W-1:0] s_stream_offset = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_found;
    logic [SLOT_W-1:0]   m_found_slot;
    logic [HANDLE_W-1:0] m_found_handle;
    logic [SIZE_W-1:0]   m_offset_in_entry;
    logic                m_evicted;
    logic [HANDLE_W-1:0] m_evicted_handle;
    logic [SIZE_W-1:0]   m_evicted_size;

    logic [HANDLE_W-1:0] ring_handle [RING_DEPTH];
    logic [SIZE_W-1:0]   ring_size [RING_DEPTH];
    int unsigned         ins_pos = 0;
    int unsigned         old_pos = 0;
    logic                ring_is_full = 1'b0;

    ring_result_t        pending_ring_results [$];
    int                  ring_errors = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         hold_off_left = 0;

    write_history_ring_with_offset_lookup_core #(
        .DEPTH       (RING_DEPTH),
        .SIZE_BITS   (SIZE_W),
        .HANDLE_BITS (HANDLE_W)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_entry_handle    (s_entry_handle),
        .s_entry_size      (s_entry_size),
        .s_stream_offset   (s_stream_offset),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_found_slot      (m_found_slot),
        .m_found_handle    (m_found_handle),
        .m_offset_in_entry (m_offset_in_entry),
        .m_evicted         (m_evicted),
        .m_evicted_handle  (m_evicted_handle),
        .m_evicted_size    (m_evicted_size)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_handle[i] = '0;
            ring_size[i]   = '0;
        end
    end

    function automatic ring_result_t predict_ring_result(
        input logic                func,
        input logic [HANDLE_W-1:0] handle,
        input logic [SIZE_W-1:0]   nbytes,
        input logic [OFFSET_W-1:0] offset
    );
        ring_result_t res;
        int unsigned  held;
        int unsigned  k;
        int unsigned  seen;
        res = '0;
        if (func == FUNC_ADD) begin
            if (ring_is_full) begin
                res.evicted        = 1'b1;
                res.evicted_handle = ring_handle[ins_pos];
                res.evicted_size   = ring_size[ins_pos];
                old_pos = (old_pos + 1) % RING_DEPTH;
            end
            ring_handle[ins_pos] = handle;
            ring_size[ins_pos]   = nbytes;
            ins_pos = (ins_pos + 1) % RING_DEPTH;
            ring_is_full = (ins_pos == old_pos);
        end else begin
            held = ring_is_full ? RING_DEPTH : (ins_pos + RING_DEPTH - old_pos) % RING_DEPTH;
            seen = 0;
            for (int i = 0; i < held; i++) begin
                k = (old_pos + i) % RING_DEPTH;
                if (ring_handle[k] != '0 && ring_size[k] != '0 && !res.found) begin
                    if (offset >= seen && offset - seen < ring_size[k]) begin
                        res.found           = 1'b1;
                        res.found_slot      = k[SLOT_W-1:0];
                        res.found_handle    = ring_handle[k];
                        res.offset_in_entry = SIZE_W'(offset - seen);
                    end else begin
                        seen += ring_size[k];
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic int unsigned ring_stream_bytes();
        int unsigned held;
        int unsigned k;
        int unsigned total;
        held = ring_is_full ? RING_DEPTH : (ins_pos + RING_DEPTH - old_pos) % RING_DEPTH;
        total = 0;
        for (int i = 0; i < held; i++) begin
            k = (old_pos + i) % RING_DEPTH;
            if (ring_handle[k] != '0) begin
                total += ring_size[k];
            end
        end
        return total;
    endfunction

    function automatic void check_field(input string name, input logic [HANDLE_W-1:0] exp_val,
                                        input logic [HANDLE_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            ring_errors++;
        end
    endfunction

    // Result side: checks each transaction and drives ready, with a counted hold-off on request.
    initial begin
        ring_result_t exp_res;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_ring_results.size() == 0) begin
                    $display("%0t: result transaction with none expected, expected none, actual %0h",
                             $time, {m_found, m_found_slot, m_found_handle, m_offset_in_entry});
                    ring_errors++;
                end else begin
                    exp_res = pending_ring_results.pop_front();
                    check_field("found", HANDLE_W'(exp_res.found), HANDLE_W'(m_found));
                    check_field("found_slot", HANDLE_W'(exp_res.found_slot),
                                HANDLE_W'(m_found_slot));
                    check_field("found_handle", exp_res.found_handle, m_found_handle);
                    check_field("offset_in_entry", HANDLE_W'(exp_res.offset_in_entry),
                                HANDLE_W'(m_offset_in_entry));
                    check_field("evicted", HANDLE_W'(exp_res.evicted), HANDLE_W'(m_evicted));
                    check_field("evicted_handle", exp_res.evicted_handle, m_evicted_handle);
                    check_field("evicted_size", HANDLE_W'(exp_res.evicted_size),
                                HANDLE_W'(m_evicted_size));
                end
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(
        input logic                func,
        input logic [HANDLE_W-1:0] handle,
        input logic [SIZE_W-1:0]   nbytes,
        input logic [OFFSET_W-1:0] offset
    );
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= func;
        s_entry_handle  <= handle;
        s_entry_size    <= nbytes;
        s_stream_offset <= offset;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_ring_results.push_back(predict_ring_result(func, handle, nbytes, offset));
    endtask

    task automatic send_random_item();
        logic                func;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   nbytes;
        logic [OFFSET_W-1:0] offset;
        int unsigned         total;
        int unsigned         pick;
        total  = ring_stream_bytes();
        func   = ($urandom_range(99) < 55) ? FUNC_FIND : FUNC_ADD;
        handle = $urandom;
        if ($urandom_range(9) == 0) begin
            handle = '0;
        end
        pick = $urandom_range(99);
        if (pick < 12) begin
            nbytes = '0;
        end else if (pick < 80) begin
            nbytes = SIZE_W'($urandom_range(64, 1));
        end else begin
            nbytes = SIZE_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            offset = OFFSET_W'($urandom_range(total));
        end else if (pick < 80) begin
            offset = OFFSET_W'(total);
        end else begin
            offset = OFFSET_W'($urandom);
        end
        send_item(func, handle, nbytes, offset);
    endtask

    task automatic wait_ring_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_ring_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(FUNC_FIND, '0, '0, '0);
        send_item(FUNC_FIND, '1, '1, '1);
        send_item(FUNC_ADD, '1, '1, '0);
        send_item(FUNC_ADD, '0, 16'd100, '1);
        send_item(FUNC_ADD, 32'h0000_1234, '0, '0);
        send_item(FUNC_ADD, 32'h0000_0001, 16'd1, '0);
        send_item(FUNC_FIND, '0, '0, 20'h0_0000);
        send_item(FUNC_FIND, '0, '0, 20'h0_FFFE);
        send_item(FUNC_FIND, '0, '0, 20'h0_FFFF);
        send_item(FUNC_FIND, '0, '0, 20'h1_0000);
        for (int i = 0; i < 6; i++) begin
            send_item(FUNC_ADD, HANDLE_W'(32'h1000_0000 + i), SIZE_W'(16'd10 + i), '0);
        end
        send_item(FUNC_FIND, '0, '0, '1);
        send_item(FUNC_ADD, 32'hA5A5_A5A5, 16'h5A5A, '0);
        send_item(FUNC_ADD, 32'h5A5A_5A5A, 16'hA5A5, '0);
        send_item(FUNC_ADD, 32'h0000_0002, 16'd3, '0);
        send_item(FUNC_FIND, '0, '0, 20'h0_0000);
        send_item(FUNC_FIND, '0, '0, 20'h0_5A5A);
        send_item(FUNC_FIND, '0, '0, 20'h0_5A60);
    endtask

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            send_random_item();
        end
    endtask

    task automatic test_receiver_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 300;
        for (int i = 0; i < 15; i++) begin
            send_random_item();
        end
    endtask

    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 28;
        for (int round = 0; round < 3; round++) begin
            for (int i = 0; i < 6; i++) begin
                send_random_item();
            end
            wait_ring_drained();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(0, 0, 90);
        test_random_phase(61, 0, 90);
        test_receiver_hold_off();
        test_random_phase(0, 61, 90);
        test_sender_pause();
        test_random_phase(28, 28, 90);
        test_random_phase(0, 0, 90);
        wait_ring_drained();
        repeat (RING_DEPTH + 10) @(posedge aclk);
        if (ring_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
